@@ src/pbpm_pkg.sv @@
// ----------------------------------------------------------------------------
// pbpm_pkg - packet buffer pool manager shared definitions
// Word formats, operation and status codes, sequencer states and defaults.
// ----------------------------------------------------------------------------
package pbpm_pkg;

   localparam int POOL_BUFFERS_DEF = 64;
   localparam int BUFFER_BYTES_DEF = 2048;

   // operation codes
   localparam logic [1:0] FN_ALLOC = 2'd0;
   localparam logic [1:0] FN_FREE  = 2'd1;
   localparam logic [1:0] FN_PUSH  = 2'd2;
   localparam logic [1:0] FN_PULL  = 2'd3;

   // status codes
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_EMPTY    = 2'd1;
   localparam logic [1:0] STAT_SHORT    = 2'd2;
   localparam logic [1:0] STAT_OVERFLOW = 2'd3;

   typedef struct packed {
      logic [1:0]  func;
      logic [5:0]  buffer_index;
      logic [11:0] byte_count;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [5:0]  result_index;
      logic [11:0] data_offset;
      logic [11:0] data_length;
   } rsp_type;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_SUB,
      S_ADD
   } state_type;

   // sequencer to datapath controls
   typedef struct packed {
      logic clearing;   // init sweep writing one entry per cycle
      logic accept;     // request word taken, memory reads launched
      logic sub_step;   // shared unit subtracts, result registered
      logic commit;     // shared unit adds, writes and result word loaded
   } ctl_type;

endpackage

@@ src/pbpm_alu.sv @@
// ----------------------------------------------------------------------------
// pbpm_alu - shared add/subtract unit
// One adder used for both passes of a request; carry out doubles as borrow.
// ----------------------------------------------------------------------------
module pbpm_alu #(
   parameter int WIDTH = 16
) (
   input  logic             sub,
   input  logic [WIDTH-1:0] op_a,
   input  logic [WIDTH-1:0] op_b,
   output logic [WIDTH-1:0] result,
   output logic             carry
);

   logic [WIDTH:0] full;

   always_comb begin
      if (sub) begin
         full = {1'b0, op_a} - {1'b0, op_b};   // top bit set: a < b
      end else begin
         full = {1'b0, op_a} + {1'b0, op_b};
      end
   end

   assign result = full[WIDTH-1:0];
   assign carry  = full[WIDTH];

endmodule

@@ src/pbpm_seq.sv @@
// ----------------------------------------------------------------------------
// pbpm_seq - request sequencer
// Runs the init sweep, then steps each request through read, subtract, add.
// ----------------------------------------------------------------------------
module pbpm_seq #(
   parameter int POOL_BUFFERS = pbpm_pkg::POOL_BUFFERS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              out_free,
   output logic                              req_ready,
   output pbpm_pkg::ctl_type                 ctl,
   output logic [$clog2(POOL_BUFFERS)-1:0]   clr_addr
);

   localparam int IDX_W = $clog2(POOL_BUFFERS);

   pbpm_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0]    clr_ff, clr_in;
   logic                clear_last;

   assign clear_last = (clr_ff == IDX_W'(POOL_BUFFERS - 1));
   assign clr_addr   = clr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pbpm_pkg::S_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      unique case (state_ff)
         pbpm_pkg::S_CLEAR: begin
            clr_in = clr_ff + IDX_W'(1);
            if (clear_last) begin
               state_in = pbpm_pkg::S_IDLE;
            end
         end
         pbpm_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = pbpm_pkg::S_SUB;
            end
         end
         pbpm_pkg::S_SUB: begin
            state_in = pbpm_pkg::S_ADD;
         end
         pbpm_pkg::S_ADD: begin
            if (out_free) begin
               state_in = pbpm_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = pbpm_pkg::S_CLEAR;
         end
      endcase
   end

   always_comb begin
      req_ready    = (state_ff == pbpm_pkg::S_IDLE);
      ctl.clearing = (state_ff == pbpm_pkg::S_CLEAR);
      ctl.accept   = (state_ff == pbpm_pkg::S_IDLE) && req_valid;
      ctl.sub_step = (state_ff == pbpm_pkg::S_SUB);
      ctl.commit   = (state_ff == pbpm_pkg::S_ADD) && out_free;
   end

endmodule

@@ src/packet_buffer_pool_manager.sv @@
// ----------------------------------------------------------------------------
// packet_buffer_pool_manager - free-list allocator for a packet buffer pool
// LIFO free stack of buffer indices plus per-buffer head/length tables.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel (req_valid/req_ready/req_data) takes one request word:
//    alloc, free, push header or pull header. rsp channel returns exactly
//    one result word per request, in order.
//  - Each word passes through accept plus registered memory read, a
//    subtract pass through the shared adder (headroom/length/count check),
//    then an add pass that writes stack, tables and the result register.
//    A new word is taken only once the previous one has left its add pass.
//  - A result waits in the output register; if rsp_ready stays low the
//    sequencer holds in its add step and req_ready stays low until the
//    register drains.
//  - After reset an init sweep loads the free stack with indices
//    0..POOL_BUFFERS-1 and zeroes the head/length tables; req_ready is
//    low during the sweep. The first alloc grants the highest index.
// ----------------------------------------------------------------------------
module packet_buffer_pool_manager #(
   parameter int POOL_BUFFERS = pbpm_pkg::POOL_BUFFERS_DEF,
   parameter int BUFFER_BYTES = pbpm_pkg::BUFFER_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pbpm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pbpm_pkg::rsp_type rsp_data
);

   localparam int IDX_W  = $clog2(POOL_BUFFERS);
   localparam int CNT_W  = $clog2(POOL_BUFFERS + 1);
   localparam int HALF   = BUFFER_BYTES / 2;
   // head + length of an entry never exceeds half the buffer
   localparam int HEAD_W = $clog2(HALF + 1);
   localparam int AW0    = (HEAD_W > 12) ? HEAD_W : 12;
   localparam int AW     = (AW0 > CNT_W) ? AW0 : CNT_W;   // shared adder width
   localparam int IW     = (IDX_W > 6) ? IDX_W : 6;

   // storage
   logic [IDX_W-1:0]  stack_mem [POOL_BUFFERS];
   logic [HEAD_W-1:0] head_mem  [POOL_BUFFERS];
   logic [HEAD_W-1:0] len_mem   [POOL_BUFFERS];

   pbpm_pkg::ctl_type ctl;
   logic [IDX_W-1:0]  clr_addr;
   logic              out_free;

   pbpm_pkg::req_type req_ff;
   logic [CNT_W-1:0]  free_count_ff, free_count_in;
   logic [IDX_W-1:0]  stk_rd_ff;
   logic [HEAD_W-1:0] head_rd_ff, len_rd_ff;
   logic [AW-1:0]     diff_ff;
   logic              borrow_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   pbpm_pkg::rsp_type rsp_ff, rsp_in;

   // addressing
   logic [IW-1:0]     req_idx_wide, idx_wide, got_wide;
   logic [IDX_W-1:0]  req_addr, idx_addr;
   logic [CNT_W-1:0]  pop_pos;
   logic              in_range;

   // shared unit
   logic [AW-1:0]     op_a, op_b, alu_r;
   logic              alu_c;
   logic [AW-1:0]     head_ext, len_ext, cnt_ext, fc_ext, half_ext;

   // write controls
   logic              stk_we, tbl_we;
   logic [IDX_W-1:0]  stk_addr, stk_wdata, tbl_addr;
   logic [HEAD_W-1:0] head_wdata, len_wdata;

   assign out_free = !rsp_valid_ff || rsp_ready;

   pbpm_seq #(
      .POOL_BUFFERS (POOL_BUFFERS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .req_ready (req_ready),
      .ctl       (ctl),
      .clr_addr  (clr_addr)
   );

   assign req_idx_wide = IW'(req_data.buffer_index);
   assign req_addr     = req_idx_wide[IDX_W-1:0];
   assign idx_wide     = IW'(req_ff.buffer_index);
   assign idx_addr     = idx_wide[IDX_W-1:0];
   assign got_wide     = IW'(stk_rd_ff);
   assign pop_pos      = free_count_ff - CNT_W'(1);   // wraps when empty, unused then
   assign in_range     = (32'(req_ff.buffer_index) < 32'(POOL_BUFFERS));

   assign head_ext = AW'(head_rd_ff);
   assign len_ext  = AW'(len_rd_ff);
   assign cnt_ext  = AW'(req_ff.byte_count);
   assign fc_ext   = AW'(free_count_ff);
   assign half_ext = AW'(HALF);

   // operand select: subtract pass checks, add pass updates
   always_comb begin
      unique case (req_ff.func)
         pbpm_pkg::FN_ALLOC: begin
            op_a = fc_ext;
            op_b = AW'(1);
         end
         pbpm_pkg::FN_FREE: begin
            op_a = fc_ext;
            op_b = ctl.sub_step ? AW'(POOL_BUFFERS) : AW'(1);
         end
         pbpm_pkg::FN_PUSH: begin
            op_a = ctl.sub_step ? head_ext : len_ext;
            op_b = cnt_ext;
         end
         pbpm_pkg::FN_PULL: begin
            op_a = ctl.sub_step ? len_ext : head_ext;
            op_b = cnt_ext;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   pbpm_alu #(
      .WIDTH (AW)
   ) u_alu (
      .sub    (ctl.sub_step),
      .op_a   (op_a),
      .op_b   (op_b),
      .result (alu_r),
      .carry  (alu_c)
   );

   // commit decode: writes, count update and result word
   always_comb begin
      stk_we        = 1'b0;
      stk_addr      = free_count_ff[IDX_W-1:0];
      stk_wdata     = idx_addr;
      tbl_we        = 1'b0;
      tbl_addr      = idx_addr;
      head_wdata    = '0;
      len_wdata     = '0;
      free_count_in = free_count_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      if (ctl.clearing) begin
         stk_we     = 1'b1;
         stk_addr   = clr_addr;
         stk_wdata  = clr_addr;
         tbl_we     = 1'b1;
         tbl_addr   = clr_addr;
      end else if (ctl.commit) begin
         rsp_valid_in        = 1'b1;
         rsp_in.result_index = req_ff.buffer_index;
         rsp_in.data_offset  = head_ext[11:0];
         rsp_in.data_length  = len_ext[11:0];
         if (req_ff.func == pbpm_pkg::FN_ALLOC) begin
            if (borrow_ff) begin
               // pool empty
               rsp_in.status       = pbpm_pkg::STAT_EMPTY;
               rsp_in.result_index = '0;
               rsp_in.data_offset  = '0;
               rsp_in.data_length  = '0;
            end else begin
               free_count_in       = diff_ff[CNT_W-1:0];
               tbl_we              = 1'b1;
               tbl_addr            = stk_rd_ff;
               head_wdata          = HEAD_W'(HALF);
               rsp_in.status       = pbpm_pkg::STAT_OK;
               rsp_in.result_index = got_wide[5:0];
               rsp_in.data_offset  = half_ext[11:0];
               rsp_in.data_length  = '0;
            end
         end else if (!in_range) begin
            rsp_in.status      = (req_ff.func == pbpm_pkg::FN_FREE) ?
                                 pbpm_pkg::STAT_OVERFLOW : pbpm_pkg::STAT_SHORT;
            rsp_in.data_offset = '0;
            rsp_in.data_length = '0;
         end else if (req_ff.func == pbpm_pkg::FN_FREE) begin
            if (!borrow_ff) begin
               // stack already full: drop
               rsp_in.status = pbpm_pkg::STAT_OVERFLOW;
            end else begin
               stk_we             = 1'b1;
               tbl_we             = 1'b1;
               free_count_in      = alu_r[CNT_W-1:0];
               rsp_in.status      = pbpm_pkg::STAT_OK;
               rsp_in.data_offset = '0;
               rsp_in.data_length = '0;
            end
         end else if (borrow_ff) begin
            // short headroom or short length
            rsp_in.status = pbpm_pkg::STAT_SHORT;
         end else if (req_ff.func == pbpm_pkg::FN_PUSH) begin
            tbl_we             = 1'b1;
            head_wdata         = diff_ff[HEAD_W-1:0];
            len_wdata          = alu_r[HEAD_W-1:0];
            rsp_in.status      = pbpm_pkg::STAT_OK;
            rsp_in.data_offset = diff_ff[11:0];
            rsp_in.data_length = alu_r[11:0];
         end else begin
            tbl_we             = 1'b1;
            head_wdata         = alu_r[HEAD_W-1:0];
            len_wdata          = diff_ff[HEAD_W-1:0];
            rsp_in.status      = pbpm_pkg::STAT_OK;
            rsp_in.data_length = diff_ff[11:0];
         end
      end
   end

   // free stack
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem[stk_addr] <= stk_wdata;
      end
      if (ctl.accept) begin
         stk_rd_ff <= stack_mem[pop_pos[IDX_W-1:0]];
      end
   end

   // head and length tables
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         head_mem[tbl_addr] <= head_wdata;
         len_mem[tbl_addr]  <= len_wdata;
      end
      if (ctl.accept) begin
         head_rd_ff <= head_mem[req_addr];
         len_rd_ff  <= len_mem[req_addr];
      end
   end

   // request capture and subtract-pass result
   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         req_ff <= req_data;
      end
      if (ctl.sub_step) begin
         diff_ff   <= alu_r;
         borrow_ff <= alu_c;
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_count_ff <= CNT_W'(POOL_BUFFERS);
         rsp_valid_ff  <= 1'b0;
      end else begin
         free_count_ff <= free_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
